@@ rtl/core/xrng_pkg.sv @@
`default_nettype none
package xrng_pkg;
    localparam logic [31:0] INIT_X = 32'd123456789;
    localparam logic [31:0] INIT_Y = 32'd362436069;
    localparam logic [31:0] INIT_Z = 32'd521288629;
    localparam logic [31:0] INIT_W = 32'd88675123;
    localparam logic [31:0] MASK31 = 32'h7fffffff;
    localparam logic [22:0] MASK23 = 23'h7fffff;

    typedef enum logic [1:0] {
        ACT_RAW   = 2'd0,
        ACT_RANGE = 2'd1,
        ACT_FRAC  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // classified job passed from front to back
    typedef struct packed {
        action_t     kind;
        logic [30:0] r;
        logic [31:0] lo;
        logic [31:0] mag;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } bk_state_t;
endpackage
`default_nettype wire

@@ rtl/core/xrng_front.sv @@
`default_nettype none
module xrng_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [31:0]   cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_action,
    input  wire logic [31:0]   s_low_bound,
    input  wire logic [31:0]   s_high_bound,
    output logic               job_valid,
    output xrng_pkg::job_t     job,
    input  wire logic          job_ready
);
    import xrng_pkg::*;

    logic [31:0] x_reg, y_reg, z_reg, w_reg;
    logic [31:0] t, w_new, temp, span;
    logic        advance;
    action_t     kind;

    assign s_ready = job_ready;
    assign kind    = action_t'(s_action);
    assign span    = s_high_bound - s_low_bound;

    always_comb begin
        t     = x_reg ^ (x_reg << 11);
        w_new = (w_reg ^ (w_reg >> 19)) ^ (t ^ (t >> 8));
        temp  = (w_new ^ (w_new << 24) ^ (w_new << 16)) & MASK31;
        case (kind)
            ACT_RAW:   advance = 1'b1;
            ACT_RANGE: advance = (span != 32'd0);
            ACT_FRAC:  advance = 1'b1;
            default:   advance = 1'b0;
        endcase
        job.kind = (kind == ACT_RANGE && span == 32'd0) ? ACT_NONE : kind;
        job.r    = temp[30:0];
        job.lo   = s_low_bound;
        job.mag  = span[31] ? (32'd0 - span) : span;
    end

    assign job_valid = s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            x_reg <= INIT_X;
            y_reg <= INIT_Y;
            z_reg <= INIT_Z;
            if (!aresetn)
                w_reg <= INIT_W;
            else
                w_reg <= (cfg_wr_data != 32'd0 && !cfg_wr_data[31]) ? cfg_wr_data : INIT_W;
        end else if (s_valid && s_ready && advance) begin
            x_reg <= y_reg;
            y_reg <= z_reg;
            z_reg <= w_reg;
            w_reg <= w_new;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/xrng_queue.sv @@
`default_nettype none
module xrng_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire xrng_pkg::job_t in_job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output xrng_pkg::job_t   out_job
);
    import xrng_pkg::*;

    job_t        mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (out_valid && out_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/xrng_back.sv @@
`default_nettype none
module xrng_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  wire xrng_pkg::job_t job,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_value,
    output logic [22:0]      m_fraction
);
    import xrng_pkg::*;

    bk_state_t   st_reg, st_next;
    logic [30:0] rem_reg, quo_bits_reg;
    logic [31:0] mag_reg, lo_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] value_reg;
    logic [22:0] frac_reg;
    logic [31:0] trial;
    logic [31:0] rem_sh;

    // restoring remainder, one dividend bit per cycle
    assign rem_sh = {rem_reg, quo_bits_reg[30]};
    assign trial  = rem_sh - mag_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE: if (job_valid) st_next = (job.kind == ACT_RANGE) ? BK_DIV : BK_OUT;
            BK_DIV:  if (cnt_reg == 5'd30) st_next = BK_OUT;
            BK_OUT:  if (m_ready) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_ready  = (st_reg == BK_IDLE);
        m_valid    = (st_reg == BK_OUT);
        m_value    = value_reg;
        m_fraction = frac_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= BK_IDLE;
        else          st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            BK_IDLE: if (job_valid) begin
                rem_reg      <= 31'd0;
                quo_bits_reg <= job.r;
                mag_reg      <= job.mag;
                lo_reg       <= job.lo;
                cnt_reg      <= 5'd0;
                value_reg    <= (job.kind == ACT_RAW) ? {1'b0, job.r} : 32'd0;
                frac_reg     <= (job.kind == ACT_FRAC) ? job.r[22:0] : 23'd0;
            end
            BK_DIV: begin
                if (!trial[31] && rem_sh >= mag_reg) rem_reg <= trial[30:0];
                else                                 rem_reg <= rem_sh[30:0];
                quo_bits_reg <= {quo_bits_reg[29:0], 1'b0};
                cnt_reg      <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                    value_reg <= ((rem_sh >= mag_reg) ? trial : rem_sh) + lo_reg;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/xorshift128_tempered_range_rng_core.sv @@
`default_nettype none
// channel  | ports                                 | direction
// s_       | s_valid s_ready s_action s_low/high   | request word in
// m_       | m_valid m_ready m_value m_fraction    | result word out
// cfg_     | cfg_wr_en cfg_wr_data                 | seed write
// the generator steps in the front stage as a raw, fraction or nonzero-span range request word is taken
// raw and fraction words go straight from idle to output in the back end, ranged ones pass a divide state first
// (one remainder bit per cycle in the back end divider)
// a two-entry queue lets the front keep taking words while the back is busy
// synchronous active-low reset reloads the default seed state
module xorshift128_tempered_range_rng_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_low_bound,
    input  wire logic [31:0] s_high_bound,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_value,
    output logic [22:0]      m_fraction
);
    import xrng_pkg::*;

    // front to queue
    logic fq_valid, fq_ready;
    job_t fq_job;
    // queue to back
    logic qb_valid, qb_ready;
    job_t qb_job;

    xrng_front u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_valid, .s_ready, .s_action, .s_low_bound, .s_high_bound,
        .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
    );

    xrng_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    xrng_back u_back (
        .aclk, .aresetn,
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .m_valid, .m_ready, .m_value, .m_fraction
    );
endmodule
`default_nettype wire
